FILE: hdl/lgs_pkg.sv
// Shared types, codes and constants of the life grid generation step block.
package lgs_pkg;

  // Fixed widths of the payload and configuration fields
  localparam int CFG_W       = 7;
  localparam int ROW_IDX_W   = 6;
  localparam int COL_IDX_W   = 6;
  localparam int CFG_IDX_W   = 1;

  // Defaults of the store size
  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  // Reset value of both size registers
  localparam int CFG_RESET = 64;

  // B3/S23 rule
  localparam int BIRTH_COUNT = 3;
  localparam int SURVIVE_LOW = 2;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Command codes
  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_ADVANCE = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_WRITE,
    OP_READ,
    OP_ADVANCE
  } op_e;

  typedef struct packed {
    logic [1:0]           command;
    logic [ROW_IDX_W-1:0] row_index;
    logic [COL_IDX_W-1:0] col_index;
    logic                 cell_value;
  } in_item_t;

  typedef struct packed {
    logic read_value;
    logic out_of_range;
  } out_item_t;

  // Classified command as it travels from front to back
  typedef struct packed {
    op_e                  kind;
    logic                 oor;
    logic [ROW_IDX_W-1:0] row_index;
    logic [COL_IDX_W-1:0] col_index;
    logic                 cell_value;
  } job_t;

  // Width of a count that holds both the register value and the store size
  function automatic int cnt_width(input int max_count);
    int w;
    w = $clog2(max_count + 1);
    return (w > CFG_W) ? w : CFG_W;
  endfunction

endpackage

FILE: hdl/lgs_front.sv
// Front end: size registers, command acceptance and classification.
module lgs_front #(
  parameter int MAX_ROWS = lgs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = lgs_pkg::MAX_COLS_DEF,
  localparam int RowW = lgs_pkg::cnt_width(MAX_ROWS),
  localparam int ColW = lgs_pkg::cnt_width(MAX_COLS)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lgs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lgs_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  lgs_pkg::in_item_t               in_data_i,
  input  logic                            init_done_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output lgs_pkg::job_t                   q_data_o,
  output logic [RowW-1:0]                 eff_rows_o,
  output logic [ColW-1:0]                 eff_cols_o
);

  localparam int RowsReset = (lgs_pkg::CFG_RESET > MAX_ROWS) ? MAX_ROWS : lgs_pkg::CFG_RESET;
  localparam int ColsReset = (lgs_pkg::CFG_RESET > MAX_COLS) ? MAX_COLS : lgs_pkg::CFG_RESET;

  logic [RowW-1:0] eff_rows_q, eff_rows_d;
  logic [ColW-1:0] eff_cols_q, eff_cols_d;
  logic [RowW-1:0] rows_wr;
  logic [ColW-1:0] cols_wr;
  logic            in_area;

  // Saturate the written count at the store size
  assign rows_wr = (RowW'(cfg_wdata_i) > RowW'(MAX_ROWS)) ? RowW'(MAX_ROWS)
                                                         : RowW'(cfg_wdata_i);
  assign cols_wr = (ColW'(cfg_wdata_i) > ColW'(MAX_COLS)) ? ColW'(MAX_COLS)
                                                         : ColW'(cfg_wdata_i);

  always_comb begin
    eff_rows_d = eff_rows_q;
    eff_cols_d = eff_cols_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        lgs_pkg::REG_ROWS: eff_rows_d = rows_wr;
        lgs_pkg::REG_COLS: eff_cols_d = cols_wr;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_rows_q <= RowW'(RowsReset);
      eff_cols_q <= ColW'(ColsReset);
    end else begin
      eff_rows_q <= eff_rows_d;
      eff_cols_q <= eff_cols_d;
    end
  end

  assign eff_rows_o = eff_rows_q;
  assign eff_cols_o = eff_cols_q;

  assign in_area = (RowW'(in_data_i.row_index) < eff_rows_q) &&
                   (ColW'(in_data_i.col_index) < eff_cols_q);

  always_comb begin
    q_data_o.row_index  = in_data_i.row_index;
    q_data_o.col_index  = in_data_i.col_index;
    q_data_o.cell_value = in_data_i.cell_value;
    q_data_o.oor        = 1'b0;
    q_data_o.kind       = lgs_pkg::OP_NOP;
    unique case (in_data_i.command)
      lgs_pkg::CMD_WRITE: begin
        q_data_o.oor  = !in_area;
        q_data_o.kind = in_area ? lgs_pkg::OP_WRITE : lgs_pkg::OP_NOP;
      end
      lgs_pkg::CMD_READ: begin
        q_data_o.oor  = !in_area;
        q_data_o.kind = in_area ? lgs_pkg::OP_READ : lgs_pkg::OP_NOP;
      end
      lgs_pkg::CMD_ADVANCE: q_data_o.kind = lgs_pkg::OP_ADVANCE;
      default: q_data_o.kind = lgs_pkg::OP_NOP;
    endcase
  end

  assign in_ready_o = init_done_i && !q_full_i;
  assign q_push_o   = in_valid_i && in_ready_o;

endmodule

FILE: hdl/lgs_queue.sv
// Short queue of classified commands between front and back.
module lgs_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lgs_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output lgs_pkg::job_t data_o
);

  localparam int Depth = lgs_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  lgs_pkg::job_t   entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wrap_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= wrap_inc(rd_ptr_q);
      if (do_push && !do_pop) count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entries_q[wr_ptr_q] <= data_i;
  end

endmodule

FILE: hdl/lgs_back.sv
// Back end: row store, clearing pass, cell access and generation sweep.
module lgs_back #(
  parameter int MAX_ROWS = lgs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = lgs_pkg::MAX_COLS_DEF,
  localparam int RowW = lgs_pkg::cnt_width(MAX_ROWS),
  localparam int ColW = lgs_pkg::cnt_width(MAX_COLS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [RowW-1:0]    eff_rows_i,
  input  logic [ColW-1:0]    eff_cols_i,
  output logic               init_done_o,
  input  logic               q_valid_i,
  input  lgs_pkg::job_t      q_data_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lgs_pkg::out_item_t out_data_o
);

  localparam int RowAW = $clog2(MAX_ROWS);
  localparam int ColAW = $clog2(MAX_COLS);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_SWEEP
  } state_e;

  state_e state_q, state_d;

  // Row store
  logic [MAX_COLS-1:0] mem_q [MAX_ROWS];
  logic [MAX_COLS-1:0] mem_rd_q;
  logic                mem_re, mem_we;
  logic [RowAW-1:0]    mem_raddr, mem_waddr;
  logic [MAX_COLS-1:0] mem_wdata;

  // Control registers
  logic [RowAW-1:0] clr_q, clr_d;
  logic             out_vld_q, out_vld_d;
  logic             issue_on_q, issue_on_d;
  logic             s1_vld_q, s1_vld_d;
  logic             s2_vld_q, s2_vld_d;

  // Payload registers
  lgs_pkg::job_t       job_q, job_d;
  lgs_pkg::out_item_t  out_q, out_d;
  logic [RowW-1:0]     issue_q, issue_d;
  logic [RowW-1:0]     s1_row_q, s1_row_d;
  logic                s1_zero_q, s1_zero_d;
  logic [RowW-1:0]     s2_row_q, s2_row_d;
  logic [MAX_COLS-1:0] prev_q, prev_d, cur_q, cur_d, next_q, next_d;
  logic [MAX_COLS-1:0] col_mask_q, col_mask_d;

  logic [MAX_COLS-1:0] life_row;
  logic [MAX_COLS-1:0] access_row;
  logic                load_out;
  logic                issue_in;
  logic                sweep_done;

  // Columns in use, registered behind the size register
  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask_d[c] = (ColW'(c) < eff_cols_i);
    end
  end

  // B3/S23 on the middle row of the window; columns outside use count dead
  always_comb begin
    logic [MAX_COLS+1:0] pp, pc, pn;
    logic [3:0]          cnt;
    pp = {1'b0, prev_q & col_mask_q, 1'b0};
    pc = {1'b0, cur_q & col_mask_q, 1'b0};
    pn = {1'b0, next_q & col_mask_q, 1'b0};
    for (int c = 0; c < MAX_COLS; c++) begin
      cnt = 4'(pp[c]) + 4'(pp[c+1]) + 4'(pp[c+2]) + 4'(pc[c]) + 4'(pc[c+2]) +
            4'(pn[c]) + 4'(pn[c+1]) + 4'(pn[c+2]);
      if (pc[c+1]) begin
        life_row[c] = (cnt == 4'(lgs_pkg::SURVIVE_LOW)) ||
                      (cnt == 4'(lgs_pkg::BIRTH_COUNT));
      end else begin
        life_row[c] = (cnt == 4'(lgs_pkg::BIRTH_COUNT));
      end
    end
  end

  always_comb begin
    access_row = mem_rd_q;
    access_row[ColAW'(job_q.col_index)] = job_q.cell_value;
  end

  assign issue_in   = (issue_q < eff_rows_i);
  assign sweep_done = s2_vld_q && (s2_row_q == eff_rows_i);

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    out_vld_d  = out_vld_q;
    issue_on_d = issue_on_q;
    s1_vld_d   = 1'b0;
    s2_vld_d   = 1'b0;
    job_d      = job_q;
    out_d      = out_q;
    issue_d    = issue_q;
    s1_row_d   = s1_row_q;
    s1_zero_d  = s1_zero_q;
    s2_row_d   = s2_row_q;
    prev_d     = prev_q;
    cur_d      = cur_q;
    next_d     = next_q;
    q_pop_o    = 1'b0;
    load_out   = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;

    if (out_vld_q && out_ready_i) out_vld_d = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == RowAW'(MAX_ROWS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        // Take a command only once the result register is sure to be free
        if (q_valid_i && (!out_vld_q || out_ready_i)) begin
          q_pop_o = 1'b1;
          job_d   = q_data_i;
          unique case (q_data_i.kind)
            lgs_pkg::OP_WRITE, lgs_pkg::OP_READ: begin
              mem_re    = 1'b1;
              mem_raddr = RowAW'(q_data_i.row_index);
              state_d   = ST_ACCESS;
            end
            lgs_pkg::OP_ADVANCE: begin
              issue_d    = '0;
              issue_on_d = 1'b1;
              prev_d     = '0;
              cur_d      = '0;
              next_d     = '0;
              state_d    = ST_SWEEP;
            end
            default: begin
              load_out           = 1'b1;
              out_d.read_value   = 1'b0;
              out_d.out_of_range = q_data_i.oor;
            end
          endcase
        end
      end
      ST_ACCESS: begin
        load_out           = 1'b1;
        out_d.out_of_range = 1'b0;
        out_d.read_value   = 1'b0;
        if (job_q.kind == lgs_pkg::OP_WRITE) begin
          mem_we    = 1'b1;
          mem_waddr = RowAW'(job_q.row_index);
          mem_wdata = access_row;
        end else begin
          out_d.read_value = mem_rd_q[ColAW'(job_q.col_index)];
        end
        state_d = ST_IDLE;
      end
      ST_SWEEP: begin
        // Fetch one row a cycle, plus one dead row below the last in use
        if (issue_on_q) begin
          mem_re    = issue_in;
          mem_raddr = RowAW'(issue_q);
          s1_vld_d  = 1'b1;
          s1_row_d  = issue_q;
          s1_zero_d = !issue_in;
          if (issue_q == eff_rows_i) issue_on_d = 1'b0;
          else                       issue_d    = issue_q + 1'b1;
        end
        // Shift the fetched row into the window
        if (s1_vld_q) begin
          prev_d   = cur_q;
          cur_d    = next_q;
          next_d   = s1_zero_q ? '0 : mem_rd_q;
          s2_vld_d = 1'b1;
          s2_row_d = s1_row_q;
        end
        // Write back the middle row; columns outside use keep their cells
        if (s2_vld_q && (s2_row_q != '0)) begin
          mem_we    = 1'b1;
          mem_waddr = RowAW'(s2_row_q - 1'b1);
          mem_wdata = (life_row & col_mask_q) | (cur_q & ~col_mask_q);
        end
        if (sweep_done) begin
          load_out = 1'b1;
          out_d    = '0;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (load_out) out_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      out_vld_q  <= 1'b0;
      issue_on_q <= 1'b0;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      out_vld_q  <= out_vld_d;
      issue_on_q <= issue_on_d;
      s1_vld_q   <= s1_vld_d;
      s2_vld_q   <= s2_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    out_q      <= out_d;
    issue_q    <= issue_d;
    s1_row_q   <= s1_row_d;
    s1_zero_q  <= s1_zero_d;
    s2_row_q   <= s2_row_d;
    prev_q     <= prev_d;
    cur_q      <= cur_d;
    next_q     <= next_d;
    col_mask_q <= col_mask_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rd_q <= mem_q[mem_raddr];
  end

  assign init_done_o = (state_q != ST_CLEAR);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_no_same_row_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("row store written and read at the same row");

  a_out_free_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_vld_q || out_ready_i))
    else $error("result loaded over a beat not yet taken");

  a_no_pop_while_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !q_pop_o)
    else $error("command taken during clearing pass");

  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q |-> (s2_row_q <= eff_rows_i))
    else $error("window ran past the rows in use");

  a_sweep_ends_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SWEEP) && sweep_done) |=> (state_q == ST_IDLE) && out_vld_q)
    else $error("sweep end did not deliver a result");

endmodule

FILE: hdl/life_grid_generation_step.sv
// Top level of the B3/S23 life grid: front end, command queue and back end.
// After reset the row store is cleared one row a cycle, and no command is taken until that
// pass ends; configuration writes are taken throughout. The back end runs one command at a
// time from a two-deep queue: a write or read of a cell fetches the row, then modifies it or
// selects the cell; an out-of-range or unused command is answered straight from idle; and an
// advance sweeps the rows in use through a three-row window, fed one row a cycle by the single
// read port of the row store. Results wait in an output register while further commands
// are queued.
module life_grid_generation_step #(
  parameter int MAX_ROWS = lgs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = lgs_pkg::MAX_COLS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lgs_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lgs_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lgs_pkg::out_item_t            out_data_o
);

  localparam int RowW = lgs_pkg::cnt_width(MAX_ROWS);
  localparam int ColW = lgs_pkg::cnt_width(MAX_COLS);

  logic            init_done;
  logic            q_full, q_push, q_pop, q_valid;
  lgs_pkg::job_t   q_wr_data, q_rd_data;
  logic [RowW-1:0] eff_rows;
  logic [ColW-1:0] eff_cols;

  lgs_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .init_done_i (init_done),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wr_data),
    .eff_rows_o  (eff_rows),
    .eff_cols_o  (eff_cols)
  );

  lgs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wr_data),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rd_data)
  );

  lgs_back #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .eff_rows_i  (eff_rows),
    .eff_cols_i  (eff_cols),
    .init_done_o (init_done),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rd_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: tb/life_grid_checker.sv
// Checker for the life grid: follows config writes, predicts each result beat and compares it.
`timescale 1ns / 1ps
module life_grid_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lgs_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  lgs_pkg::in_item_t             in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  lgs_pkg::out_item_t            out_data_i,
  output int                            mismatches_o,
  output int                            awaiting_o
);

  localparam int SHOW_LIMIT = 10;

  logic [lgs_pkg::MAX_COLS_DEF-1:0] cells [lgs_pkg::MAX_ROWS_DEF];
  logic [lgs_pkg::CFG_W-1:0]        rows_reg;
  logic [lgs_pkg::CFG_W-1:0]        cols_reg;
  lgs_pkg::out_item_t               due_results [$];
  int                               fails;
  int                               shown;

  function automatic int rows_active();
    return (int'(rows_reg) > lgs_pkg::MAX_ROWS_DEF) ? lgs_pkg::MAX_ROWS_DEF : int'(rows_reg);
  endfunction

  function automatic int cols_active();
    return (int'(cols_reg) > lgs_pkg::MAX_COLS_DEF) ? lgs_pkg::MAX_COLS_DEF : int'(cols_reg);
  endfunction

  // One B3/S23 generation over the area in use; cells beyond it hold and count as dead
  function automatic void advance_cells();
    logic [lgs_pkg::MAX_COLS_DEF-1:0] nxt [lgs_pkg::MAX_ROWS_DEF];
    int nr, nc, n, rr, cc;
    nr  = rows_active();
    nc  = cols_active();
    nxt = cells;
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            rr = r + dr;
            cc = c + dc;
            if ((dr != 0 || dc != 0) && rr >= 0 && rr < nr && cc >= 0 && cc < nc)
              n += int'(cells[rr][cc]);
          end
        end
        if (cells[r][c]) begin
          nxt[r][c] = (n == lgs_pkg::SURVIVE_LOW) || (n == lgs_pkg::BIRTH_COUNT);
        end else begin
          nxt[r][c] = (n == lgs_pkg::BIRTH_COUNT);
        end
      end
    end
    cells = nxt;
  endfunction

  function automatic lgs_pkg::out_item_t apply_command(input lgs_pkg::in_item_t item);
    lgs_pkg::out_item_t res;
    logic               hit;
    res = '0;
    hit = (int'(item.row_index) < rows_active()) && (int'(item.col_index) < cols_active());
    case (item.command)
      lgs_pkg::CMD_WRITE: begin
        if (hit) cells[item.row_index][item.col_index] = item.cell_value;
        else res.out_of_range = 1'b1;
      end
      lgs_pkg::CMD_READ: begin
        if (hit) res.read_value = cells[item.row_index][item.col_index];
        else res.out_of_range = 1'b1;
      end
      lgs_pkg::CMD_ADVANCE: begin
        advance_cells();
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lgs_pkg::out_item_t want;
    lgs_pkg::out_item_t next_due;
    if (!rst_ni) begin
      for (int r = 0; r < lgs_pkg::MAX_ROWS_DEF; r++) cells[r] = '0;
      rows_reg = lgs_pkg::CFG_RESET[lgs_pkg::CFG_W-1:0];
      cols_reg = lgs_pkg::CFG_RESET[lgs_pkg::CFG_W-1:0];
      due_results.delete();
      fails = 0;
      shown = 0;
    end else begin
      // Take the result beat first: it can only belong to an earlier command
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          fails++;
          if (shown < SHOW_LIMIT) begin
            shown++;
            $display("%0t: result beat with nothing due: read_value %0b out_of_range %0b",
                     $realtime, out_data_i.read_value, out_data_i.out_of_range);
          end
        end else begin
          want = due_results.pop_front();
          if (out_data_i.read_value !== want.read_value ||
              out_data_i.out_of_range !== want.out_of_range) begin
            fails++;
            if (shown < SHOW_LIMIT) begin
              shown++;
              $display("%0t: mismatch: read_value exp %0b got %0b, out_of_range exp %0b got %0b",
                       $realtime, want.read_value, out_data_i.read_value,
                       want.out_of_range, out_data_i.out_of_range);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        next_due    = apply_command(in_data_i);
        due_results = {due_results, next_due};
      end
      if (cfg_we_i) begin
        if (cfg_index_i == lgs_pkg::REG_ROWS) rows_reg = cfg_wdata_i;
        else cols_reg = cfg_wdata_i;
      end
    end
    mismatches_o <= fails;
    awaiting_o   <= due_results.size();
  end

endmodule

FILE: tb/tb.sv
// Testbench top for the life grid: clock, reset, command stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb;

  localparam logic [1:0] CMD_SPARE     = 2'd3;
  localparam int         QUIET_LIMIT   = 3000;
  localparam int         SETTLE_CYCLES = 80;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lgs_pkg::CFG_W-1:0]     cfg_wdata;
  logic                          in_valid;
  logic                          in_ready;
  lgs_pkg::in_item_t             in_data;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  lgs_pkg::out_item_t            out_data;

  int mismatches;
  int awaiting;
  int send_idle_pct = 29;
  int recv_idle_pct = 71;
  int quiet_cycles  = 0;
  int rows_live     = lgs_pkg::MAX_ROWS_DEF;
  int cols_live     = lgs_pkg::MAX_COLS_DEF;

  life_grid_generation_step DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  life_grid_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .mismatches_o (mismatches),
    .awaiting_o   (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Count cycles without any beat or register write
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("life_grid_generation_step test failed");
    $finish;
  end

  task automatic issue(input logic [1:0] cmd, input int row, input int col, input logic val);
    lgs_pkg::in_item_t item;
    item.command    = cmd;
    item.row_index  = row[lgs_pkg::ROW_IDX_W-1:0];
    item.col_index  = col[lgs_pkg::COL_IDX_W-1:0];
    item.cell_value = val;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and wait until every due result beat has gone out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  task automatic set_size(input int rows, input int cols);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= lgs_pkg::REG_ROWS;
    cfg_wdata <= rows[lgs_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_index <= lgs_pkg::REG_COLS;
    cfg_wdata <= cols[lgs_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    rows_live = (rows > lgs_pkg::MAX_ROWS_DEF) ? lgs_pkg::MAX_ROWS_DEF : rows;
    cols_live = (cols > lgs_pkg::MAX_COLS_DEF) ? lgs_pkg::MAX_COLS_DEF : cols;
  endtask

  // Mostly in-range writes, reads and advances; the rest stray indexes and the spare code
  task automatic random_item();
    int   pick, row, col;
    logic val;
    pick = $urandom_range(99);
    row  = $urandom_range(63);
    col  = $urandom_range(63);
    val  = 1'($urandom_range(1));
    if (pick < 65 && rows_live != 0 && cols_live != 0) begin
      row = $urandom_range(rows_live - 1);
      col = $urandom_range(cols_live - 1);
    end
    if (pick < 50) issue(lgs_pkg::CMD_WRITE, row, col, ($urandom_range(99) < 45));
    else if (pick < 65) issue(lgs_pkg::CMD_READ, row, col, val);
    else if (pick < 80) issue(lgs_pkg::CMD_ADVANCE, row, col, val);
    else if (pick < 93) begin
      issue(($urandom_range(1) != 0) ? lgs_pkg::CMD_WRITE : lgs_pkg::CMD_READ, row, col, val);
    end
    else issue(CMD_SPARE, row, col, val);
  endtask

  task automatic run_phase(input int rows, input int cols, input int items,
                           input int send_pct, input int recv_pct);
    set_size(rows, cols);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (items) random_item();
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = lgs_pkg::REG_ROWS;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Full grid straight after reset: corners, and no wrap-around at row and column zero
    issue(lgs_pkg::CMD_READ, 0, 0, 1'b0);
    issue(lgs_pkg::CMD_WRITE, 63, 63, 1'b1);
    issue(lgs_pkg::CMD_READ, 63, 63, 1'b0);
    issue(lgs_pkg::CMD_WRITE, 0, 0, 1'b1);
    issue(lgs_pkg::CMD_WRITE, 0, 1, 1'b1);
    issue(lgs_pkg::CMD_WRITE, 1, 0, 1'b1);
    issue(lgs_pkg::CMD_WRITE, 63, 0, 1'b1);
    issue(lgs_pkg::CMD_WRITE, 0, 63, 1'b1);
    issue(lgs_pkg::CMD_ADVANCE, 63, 63, 1'b1);
    issue(lgs_pkg::CMD_READ, 1, 1, 1'b1);
    issue(lgs_pkg::CMD_READ, 0, 0, 1'b0);
    issue(lgs_pkg::CMD_READ, 63, 63, 1'b0);
    issue(CMD_SPARE, 63, 63, 1'b1);
    issue(CMD_SPARE, 0, 0, 1'b0);
    issue(lgs_pkg::CMD_WRITE, 1, 1, 1'b0);

    // No cell in use
    set_size(0, 0);
    issue(lgs_pkg::CMD_WRITE, 0, 0, 1'b1);
    issue(lgs_pkg::CMD_READ, 0, 0, 1'b0);
    issue(lgs_pkg::CMD_ADVANCE, 0, 0, 1'b0);

    // Register beyond the store saturates
    set_size(127, 127);
    issue(lgs_pkg::CMD_READ, 0, 1, 1'b0);
    issue(lgs_pkg::CMD_WRITE, 63, 62, 1'b1);

    // Tiny grid: stray indexes, and cells beyond it must hold
    set_size(3, 3);
    issue(lgs_pkg::CMD_WRITE, 3, 0, 1'b1);
    issue(lgs_pkg::CMD_READ, 0, 3, 1'b0);
    issue(lgs_pkg::CMD_WRITE, 2, 2, 1'b1);
    issue(lgs_pkg::CMD_ADVANCE, 5, 5, 1'b1);
    issue(lgs_pkg::CMD_READ, 2, 2, 1'b0);

    run_phase(64, 64, 60, 29, 71);
    run_phase(5, 5, 200, 29, 71);
    run_phase(8, 6, 200, 29, 71);
    run_phase(0, 0, 30, 29, 71);
    run_phase(3, 3, 200, 71, 29);
    run_phase(127, 127, 60, 71, 29);
    run_phase(1, 64, 80, 71, 29);
    run_phase(64, 1, 80, 71, 29);
    run_phase(12, 10, 250, 0, 0);
    run_phase(4, 7, 200, 0, 0);
    run_phase(1, 1, 60, 0, 0);
    run_phase(16, 16, 250, 0, 0);
    run_phase(6, 9, 260, 0, 0);

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("life_grid_generation_step test passed");
    else $display("life_grid_generation_step test failed");
    $finish;
  end

endmodule
